FILE: rtl/cws_pkg.sv
// ----------------------------------------------------------------------------
// cws_pkg: shared types and constants of the calcium-window synapse
// Command codes, register indexes and the config bundles that the top level
// hands to the drift and post-update units.
// ----------------------------------------------------------------------------
package cws_pkg;

	// item commands
	typedef enum logic [2:0] {
		CMD_SPIKE   = 3'd0,
		CMD_POST    = 3'd1,
		CMD_CATCHUP = 3'd2,
		CMD_RESYNC  = 3'd3,
		CMD_LOAD    = 3'd4
	} cmd_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MODE          = 3'd0,
		REG_POT_THRESHOLD = 3'd1,
		REG_CA_UP_WINDOW  = 3'd2,
		REG_CA_DN_WINDOW  = 3'd3,
		REG_STEP_AMOUNTS  = 3'd4,
		REG_DRIFT_RATES   = 3'd5,
		REG_DRIFT_THRESH  = 3'd6,
		REG_DRIFT_BOUNDS  = 3'd7
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned CFG_DATA_BITS = 32;
	localparam int unsigned WEIGHT_BITS   = 16;

	// elapsed-step saturation for drift catch-up
	localparam int unsigned          CAP_BITS    = 21;
	localparam logic [CAP_BITS-1:0]  ELAPSED_CAP = 21'h10_0000;

	// mode bits
	localparam int unsigned MODE_LEARN   = 0;
	localparam int unsigned MODE_DISABLE = 1;

	// register reset values
	localparam logic [15:0] DRIFT_THRESH_RST = 16'h4000;
	localparam logic [31:0] DRIFT_BOUNDS_RST = 32'h8000_0000;

	typedef struct packed {
		logic [15:0] rate_up;
		logic [15:0] rate_down;
		logic [15:0] threshold;
		logic [15:0] floor_v;
		logic [15:0] ceil_v;
	} drift_cfg_t;

	typedef struct packed {
		logic signed [15:0] pot_thr;
		logic signed [15:0] up_lo;
		logic signed [15:0] up_hi;
		logic signed [15:0] dn_lo;
		logic signed [15:0] dn_hi;
		logic        [15:0] inc;
		logic        [15:0] dec;
	} post_cfg_t;

	// registered input item
	typedef struct packed {
		cmd_t               cmd;
		logic        [31:0] time_step;
		logic signed [15:0] membrane_potential;
		logic signed [15:0] calcium_level;
		logic        [15:0] load_value;
	} item_t;

endpackage

FILE: rtl/calcium_window_synapse_plasticity_unit.sv
// ----------------------------------------------------------------------------
// calcium_window_synapse_plasticity_unit: one plastic synapse
// Q1.15 weight with calcium-window learning and lazy drift.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beats arrive on s_* (cmd in s_tuser); each beat yields exactly one
//    result beat on m_* with the weight after the command, its 7-bit byte
//    form and the spike relay flag.
//  - Input beats land in an input register (_s1); the weight, step and spike
//    state update and the result register loads in the cycle the item leaves
//    that register; m_tvalid is driven from the result register.
//  - Throughput: one beat per cycle while m_tready is high. The whole
//    update (elapsed-step subtract, one 16x21 drift multiply, window
//    compares, clamps) sits between the input and result registers.
//  - When the receiver stalls, the result register holds and the input
//    register fills; s_tready drops only while both are full.
//  - Config writes (cfg_we/cfg_index/cfg_wdata) take effect at the clock
//    edge; write only while no beat is in flight.
//  - Reset (arst_n low) empties both registers, clears the weight and last
//    update step, marks no spike seen and restores register defaults.
// ----------------------------------------------------------------------------
module calcium_window_synapse_plasticity_unit #(
	parameter int unsigned WEIGHT_MAX = 32768,
	parameter int unsigned STEP_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [cws_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [cws_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// time_step[31:0], membrane_potential[47:32], calcium_level[63:48],
	// load_value[79:64]
	input  logic [79:0]                         s_tdata,
	// cmd[2:0]
	input  logic [2:0]                          s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// weight_now[15:0], weight_byte[22:16], spike_relayed[23]
	output logic [23:0]                         m_tdata
);

	// config registers
	logic [1:0]  mode_q;
	logic [15:0] pot_thr_q;
	logic [31:0] ca_up_q;
	logic [31:0] ca_dn_q;
	logic [31:0] step_amt_q;
	logic [31:0] drift_rates_q;
	logic [15:0] drift_thr_q;
	logic [31:0] drift_bounds_q;

	// synapse state
	logic [15:0]          weight_q;
	logic [STEP_BITS-1:0] last_upd_q;
	logic [STEP_BITS-1:0] last_spk_q;
	logic                 spk_valid_q;

	// input register
	logic            valid_s1;
	cws_pkg::item_t  item_s1;
	logic            advance;

	// result register
	logic        out_valid_q;
	logic [15:0] out_weight_q;
	logic        out_relay_q;

	// update logic
	logic [STEP_BITS-1:0] now;
	logic [STEP_BITS-1:0] elapsed;
	logic [STEP_BITS-1:0] drift_n;
	logic                 learn;
	logic                 disabled;
	logic [15:0]          drift_w;
	logic [15:0]          post_w;
	logic                 post_hit;
	logic [15:0]          weight_nx;
	logic [STEP_BITS-1:0] last_upd_nx;
	logic [STEP_BITS-1:0] last_spk_nx;
	logic                 spk_valid_nx;
	logic                 relay_nx;
	cws_pkg::drift_cfg_t  drift_cfg;
	cws_pkg::post_cfg_t   post_cfg;

	// weight byte rounding
	logic [22:0] prod127;
	logic [7:0]  byte_q;
	logic [7:0]  byte_r;

	// ---------------- config port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= '0;
			pot_thr_q      <= '0;
			ca_up_q        <= '0;
			ca_dn_q        <= '0;
			step_amt_q     <= '0;
			drift_rates_q  <= '0;
			drift_thr_q    <= cws_pkg::DRIFT_THRESH_RST;
			drift_bounds_q <= cws_pkg::DRIFT_BOUNDS_RST;
		end else if (cfg_we) begin
			case (cws_pkg::cfg_idx_t'(cfg_index))
				cws_pkg::REG_MODE:          mode_q         <= cfg_wdata[1:0];
				cws_pkg::REG_POT_THRESHOLD: pot_thr_q      <= cfg_wdata[15:0];
				cws_pkg::REG_CA_UP_WINDOW:  ca_up_q        <= cfg_wdata;
				cws_pkg::REG_CA_DN_WINDOW:  ca_dn_q        <= cfg_wdata;
				cws_pkg::REG_STEP_AMOUNTS:  step_amt_q     <= cfg_wdata;
				cws_pkg::REG_DRIFT_RATES:   drift_rates_q  <= cfg_wdata;
				cws_pkg::REG_DRIFT_THRESH:  drift_thr_q    <= cfg_wdata[15:0];
				cws_pkg::REG_DRIFT_BOUNDS:  drift_bounds_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign learn    = mode_q[cws_pkg::MODE_LEARN];
	assign disabled = mode_q[cws_pkg::MODE_DISABLE];

	assign drift_cfg = '{
		rate_up:   drift_rates_q[15:0],
		rate_down: drift_rates_q[31:16],
		threshold: drift_thr_q,
		floor_v:   drift_bounds_q[15:0],
		ceil_v:    drift_bounds_q[31:16]
	};

	assign post_cfg = '{
		pot_thr: pot_thr_q,
		up_lo:   ca_up_q[15:0],
		up_hi:   ca_up_q[31:16],
		dn_lo:   ca_dn_q[15:0],
		dn_hi:   ca_dn_q[31:16],
		inc:     step_amt_q[15:0],
		dec:     step_amt_q[31:16]
	};

	// ---------------- handshake ----------------
	// item leaves the input register when the result register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd                <= cws_pkg::cmd_t'(s_tuser);
			item_s1.time_step          <= s_tdata[31:0];
			item_s1.membrane_potential <= s_tdata[47:32];
			item_s1.calcium_level      <= s_tdata[63:48];
			item_s1.load_value         <= s_tdata[79:64];
		end
	end

	// ---------------- update logic ----------------
	assign now     = STEP_BITS'(item_s1.time_step);
	assign elapsed = now - last_upd_q;

	// spike excludes the current step; post update drifts one step
	always_comb begin
		case (item_s1.cmd)
			cws_pkg::CMD_SPIKE: drift_n = elapsed - STEP_BITS'(1);
			cws_pkg::CMD_POST:  drift_n = STEP_BITS'(1);
			default:            drift_n = elapsed;
		endcase
	end

	cws_drift #(
		.WEIGHT_MAX (WEIGHT_MAX),
		.STEP_BITS  (STEP_BITS)
	) u_drift (
		.weight     (weight_q),
		.steps      (drift_n),
		.cfg        (drift_cfg),
		.weight_out (drift_w)
	);

	cws_post #(
		.WEIGHT_MAX (WEIGHT_MAX)
	) u_post (
		.weight             (weight_q),
		.membrane_potential (item_s1.membrane_potential),
		.calcium_level      (item_s1.calcium_level),
		.cfg                (post_cfg),
		.hit                (post_hit),
		.weight_out         (post_w)
	);

	always_comb begin
		weight_nx    = weight_q;
		last_upd_nx  = last_upd_q;
		last_spk_nx  = last_spk_q;
		spk_valid_nx = spk_valid_q;
		relay_nx     = 1'b0;
		case (item_s1.cmd)
			cws_pkg::CMD_SPIKE: begin
				if (!disabled) begin
					if (learn) begin
						if (elapsed != '0) begin
							weight_nx   = drift_w;
							last_upd_nx = now;
						end
						last_spk_nx  = now;
						spk_valid_nx = 1'b1;
					end
					relay_nx = 1'b1;
				end
			end
			cws_pkg::CMD_POST: begin
				// only in the step that carried the spike
				if (learn && spk_valid_q && last_spk_q == now) begin
					weight_nx = post_hit ? post_w : drift_w;
				end
			end
			cws_pkg::CMD_CATCHUP: begin
				if (learn && elapsed != '0) begin
					weight_nx   = drift_w;
					last_upd_nx = now;
				end
			end
			cws_pkg::CMD_RESYNC: begin
				last_upd_nx = now;
			end
			cws_pkg::CMD_LOAD: begin
				weight_nx = (item_s1.load_value > 16'(WEIGHT_MAX)) ? 16'(WEIGHT_MAX)
					: item_s1.load_value;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= '0;
			last_upd_q  <= '0;
			last_spk_q  <= '1;
			spk_valid_q <= 1'b0;
		end else if (advance) begin
			weight_q    <= weight_nx;
			last_upd_q  <= last_upd_nx;
			last_spk_q  <= last_spk_nx;
			spk_valid_q <= spk_valid_nx;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_weight_q <= weight_nx;
			out_relay_q  <= relay_nx;
		end
	end

	// weight * 127 / 32768, round half to even
	assign prod127 = (23'(out_weight_q) << 7) - 23'(out_weight_q);
	assign byte_q  = prod127[22:15];
	assign byte_r  = ((prod127[14:0] > 15'h4000)
		|| (prod127[14:0] == 15'h4000 && byte_q[0])) ? byte_q + 8'd1 : byte_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_relay_q, byte_r[6:0], out_weight_q};

endmodule

FILE: rtl/cws_drift.sv
// ----------------------------------------------------------------------------
// cws_drift: lazy weight drift over n steps
// Saturates n, multiplies by the per-step rate, moves the weight toward the
// ceiling or floor and clamps to 0..WEIGHT_MAX.
// ----------------------------------------------------------------------------
module cws_drift #(
	parameter int unsigned WEIGHT_MAX = 32768,
	parameter int unsigned STEP_BITS  = 32
) (
	input  logic [cws_pkg::WEIGHT_BITS-1:0] weight,
	input  logic [STEP_BITS-1:0]            steps,
	input  cws_pkg::drift_cfg_t             cfg,
	output logic [cws_pkg::WEIGHT_BITS-1:0] weight_out
);

	localparam int unsigned NW = (STEP_BITS > cws_pkg::CAP_BITS) ? STEP_BITS
		: cws_pkg::CAP_BITS;
	localparam int unsigned PW = cws_pkg::CAP_BITS + 16;

	logic [NW-1:0]                 n_w;
	logic [cws_pkg::CAP_BITS-1:0]  n_c;
	logic [15:0]                   rate;
	logic [PW-1:0]                 prod;
	logic [PW:0]                   sum;
	logic [15:0]                   diff;
	logic [15:0]                   v;

	assign n_w  = NW'(steps);
	assign n_c  = (n_w > NW'(cws_pkg::ELAPSED_CAP)) ? cws_pkg::ELAPSED_CAP
		: n_w[cws_pkg::CAP_BITS-1:0];
	assign rate = (weight > cfg.threshold) ? cfg.rate_up : cfg.rate_down;
	assign prod = PW'(rate) * PW'(n_c);
	assign sum  = (PW+1)'(weight) + (PW+1)'(prod);
	assign diff = weight - prod[15:0];

	always_comb begin
		if (weight > cfg.threshold) begin
			v = (sum > (PW+1)'(cfg.ceil_v)) ? cfg.ceil_v : sum[15:0];
		end else if (prod > PW'(weight)) begin
			v = cfg.floor_v;
		end else begin
			v = (diff < cfg.floor_v) ? cfg.floor_v : diff;
		end
		weight_out = (v > 16'(WEIGHT_MAX)) ? 16'(WEIGHT_MAX) : v;
	end

endmodule

FILE: rtl/cws_post.sv
// ----------------------------------------------------------------------------
// cws_post: calcium-window plasticity decision
// Picks potentiation or depression by membrane potential, checks the calcium
// window and gives the stepped, clamped weight.
// ----------------------------------------------------------------------------
module cws_post #(
	parameter int unsigned WEIGHT_MAX = 32768
) (
	input  logic [cws_pkg::WEIGHT_BITS-1:0] weight,
	input  logic signed [15:0]              membrane_potential,
	input  logic signed [15:0]              calcium_level,
	input  cws_pkg::post_cfg_t              cfg,
	output logic                            hit,
	output logic [cws_pkg::WEIGHT_BITS-1:0] weight_out
);

	logic        pot_up;
	logic        in_up;
	logic        in_dn;
	logic [16:0] up_sum;

	assign pot_up = membrane_potential > $signed(cfg.pot_thr);
	assign in_up  = (calcium_level > $signed(cfg.up_lo)) && (calcium_level < $signed(cfg.up_hi));
	assign in_dn  = (calcium_level > $signed(cfg.dn_lo)) && (calcium_level < $signed(cfg.dn_hi));
	assign up_sum = 17'(weight) + 17'(cfg.inc);

	always_comb begin
		if (pot_up) begin
			hit        = in_up;
			weight_out = (up_sum > 17'(WEIGHT_MAX)) ? 16'(WEIGHT_MAX) : up_sum[15:0];
		end else begin
			hit        = in_dn;
			weight_out = (cfg.dec > weight) ? '0 : weight - cfg.dec;
		end
	end

endmodule
